[rtl/tskf_pkg.sv]
// Package for the two-state Kalman filter: widths, register map, micro-program
// and command types shared by the interfaces, controller, datapath and divider.
// No dependencies.
`default_nettype none

package tskf_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int ACC_W     = 2 * DATA_W + 2;
  localparam int RAM_DEPTH = 32;
  localparam int ADDR_W    = $clog2(RAM_DEPTH);
  localparam int SRC_W     = ADDR_W + 1;
  localparam int PC_W      = 6;
  localparam int DT_W      = 17;
  localparam int NOISE_W   = 31;
  localparam int PADDR_W   = 5;

  localparam logic [DATA_W-1:0] ONE = DATA_W'(1) << FRAC_BITS;
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);

  // Divider: dividend is |num| shifted up by FRAC_BITS, padded to an even width.
  localparam int DIV_Q_W   = ((DATA_W + FRAC_BITS + 1) / 2) * 2;
  localparam int DIV_ITER  = DIV_Q_W / 2;
  localparam int DIV_CNT_W = $clog2(DIV_ITER + 1);

  // Configuration register indexes and reset values.
  localparam logic [2:0] REG_STEP_TIME  = 3'd0;
  localparam logic [2:0] REG_PNOISE_ANG = 3'd1;
  localparam logic [2:0] REG_PNOISE_RAT = 3'd2;
  localparam logic [2:0] REG_MNOISE_ANG = 3'd3;
  localparam logic [2:0] REG_MNOISE_RAT = 3'd4;

  localparam logic [DT_W-1:0]    STEP_TIME_RST  = DT_W'(328);
  localparam logic [NOISE_W-1:0] PNOISE_ANG_RST = NOISE_W'(65536);
  localparam logic [NOISE_W-1:0] PNOISE_RAT_RST = NOISE_W'(65536);
  localparam logic [NOISE_W-1:0] MNOISE_ANG_RST = NOISE_W'(19660800);
  localparam logic [NOISE_W-1:0] MNOISE_RAT_RST = NOISE_W'(32768000);

  localparam logic OP_STEP   = 1'b0;
  localparam logic OP_RELOAD = 1'b1;

  typedef struct packed {
    logic [DT_W-1:0]    step_time;
    logic [NOISE_W-1:0] process_noise_angle;
    logic [NOISE_W-1:0] process_noise_rate;
    logic [NOISE_W-1:0] meas_noise_angle;
    logic [NOISE_W-1:0] meas_noise_rate;
  } cfg_t;

  // Operand sources: codes below RAM_DEPTH are scratch RAM entries.
  localparam logic [SRC_W-1:0] R_EST0 = 6'd0;
  localparam logic [SRC_W-1:0] R_EST1 = 6'd1;
  localparam logic [SRC_W-1:0] R_P00  = 6'd2;
  localparam logic [SRC_W-1:0] R_P01  = 6'd3;
  localparam logic [SRC_W-1:0] R_P10  = 6'd4;
  localparam logic [SRC_W-1:0] R_P11  = 6'd5;
  localparam logic [SRC_W-1:0] R_XA   = 6'd6;
  localparam logic [SRC_W-1:0] R_M00  = 6'd7;
  localparam logic [SRC_W-1:0] R_M01  = 6'd8;
  localparam logic [SRC_W-1:0] R_N00  = 6'd9;
  localparam logic [SRC_W-1:0] R_N10  = 6'd10;
  localparam logic [SRC_W-1:0] R_N11  = 6'd11;
  localparam logic [SRC_W-1:0] R_S00  = 6'd12;
  localparam logic [SRC_W-1:0] R_S11  = 6'd13;
  localparam logic [SRC_W-1:0] R_DET  = 6'd14;
  localparam logic [SRC_W-1:0] R_I00  = 6'd15;
  localparam logic [SRC_W-1:0] R_I01  = 6'd16;
  localparam logic [SRC_W-1:0] R_I10  = 6'd17;
  localparam logic [SRC_W-1:0] R_I11  = 6'd18;
  localparam logic [SRC_W-1:0] R_K00  = 6'd19;
  localparam logic [SRC_W-1:0] R_K01  = 6'd20;
  localparam logic [SRC_W-1:0] R_K10  = 6'd21;
  localparam logic [SRC_W-1:0] R_K11  = 6'd22;
  localparam logic [SRC_W-1:0] R_YA   = 6'd23;
  localparam logic [SRC_W-1:0] R_YR   = 6'd24;
  localparam logic [SRC_W-1:0] R_T00  = 6'd25;
  localparam logic [SRC_W-1:0] R_T01  = 6'd26;
  localparam logic [SRC_W-1:0] R_T10  = 6'd27;
  localparam logic [SRC_W-1:0] R_T11  = 6'd28;
  localparam logic [SRC_W-1:0] R_TMP  = 6'd29;
  localparam logic [SRC_W-1:0] C_ONE  = 6'd32;
  localparam logic [SRC_W-1:0] C_DT   = 6'd33;
  localparam logic [SRC_W-1:0] C_ZERO = 6'd34;
  localparam logic [SRC_W-1:0] C_QA   = 6'd35;
  localparam logic [SRC_W-1:0] C_QR   = 6'd36;
  localparam logic [SRC_W-1:0] C_RA   = 6'd37;
  localparam logic [SRC_W-1:0] C_RR   = 6'd38;
  localparam logic [SRC_W-1:0] C_ZA   = 6'd39;
  localparam logic [SRC_W-1:0] C_ZR   = 6'd40;

  // Entries holding the estimate and covariance; the clearing pass zeroes these.
  localparam int STATE_ENTRIES = 6;

  typedef enum logic [2:0] {
    K_DOT,
    K_DET,
    K_ADD,
    K_SUB,
    K_DIV
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [SRC_W-1:0]  a;
    logic [SRC_W-1:0]  b;
    logic [SRC_W-1:0]  c;
    logic [SRC_W-1:0]  d;
    logic [ADDR_W-1:0] dst;
  } instr_t;

  localparam logic [PC_W-1:0] OP0_FIRST = 6'd0;
  localparam logic [PC_W-1:0] OP0_LAST  = 6'd33;
  localparam logic [PC_W-1:0] OP1_FIRST = 6'd34;
  localparam logic [PC_W-1:0] OP1_LAST  = 6'd35;

  typedef struct packed {
    logic              rd;
    logic [SRC_W-1:0]  src_a;
    logic [SRC_W-1:0]  src_b;
    logic              mul_en;
    logic              acc_load;
    logic              acc_add;
    logic              acc_sub;
    logic              round_wr;
    logic              addsub_wr;
    logic              sub;
    logic              div_start;
    logic              div_wr;
    logic              clr_wr;
    logic [ADDR_W-1:0] dst;
    logic              load_z;
    logic              clear_sat;
    logic              out_load;
  } cmd_t;

  function automatic instr_t mk(input kind_e k, input logic [SRC_W-1:0] a,
                                input logic [SRC_W-1:0] b, input logic [SRC_W-1:0] c,
                                input logic [SRC_W-1:0] d, input logic [SRC_W-1:0] dst);
    instr_t i;
    i.kind = k;
    i.a    = a;
    i.b    = b;
    i.c    = c;
    i.d    = d;
    i.dst  = dst[ADDR_W-1:0];
    return i;
  endfunction

  // Micro-program. Two-operand ops use a and b; dot products form a*b + c*d,
  // the determinant a*b - c*d; divisions take a / b.
  function automatic instr_t prog(input logic [PC_W-1:0] pc);
    instr_t i;
    case (pc)
      6'd0:  i = mk(K_DOT, R_EST0, C_ONE, R_EST1, C_DT, R_XA);
      6'd1:  i = mk(K_DOT, R_P00, C_ONE, R_P10, C_DT, R_M00);
      6'd2:  i = mk(K_DOT, R_P01, C_ONE, R_P11, C_DT, R_M01);
      6'd3:  i = mk(K_DOT, R_M00, C_ONE, R_M01, C_DT, R_TMP);
      6'd4:  i = mk(K_ADD, R_TMP, C_QA, C_ZERO, C_ZERO, R_N00);
      6'd5:  i = mk(K_DOT, R_P10, C_ONE, R_P11, C_DT, R_N10);
      6'd6:  i = mk(K_ADD, R_P11, C_QR, C_ZERO, C_ZERO, R_N11);
      6'd7:  i = mk(K_ADD, R_N00, C_RA, C_ZERO, C_ZERO, R_S00);
      6'd8:  i = mk(K_ADD, R_N11, C_RR, C_ZERO, C_ZERO, R_S11);
      6'd9:  i = mk(K_DET, R_S00, R_S11, R_M01, R_N10, R_DET);
      6'd10: i = mk(K_DIV, R_S11, R_DET, C_ZERO, C_ZERO, R_I00);
      6'd11: i = mk(K_SUB, C_ZERO, R_M01, C_ZERO, C_ZERO, R_TMP);
      6'd12: i = mk(K_DIV, R_TMP, R_DET, C_ZERO, C_ZERO, R_I01);
      6'd13: i = mk(K_SUB, C_ZERO, R_N10, C_ZERO, C_ZERO, R_TMP);
      6'd14: i = mk(K_DIV, R_TMP, R_DET, C_ZERO, C_ZERO, R_I10);
      6'd15: i = mk(K_DIV, R_S00, R_DET, C_ZERO, C_ZERO, R_I11);
      6'd16: i = mk(K_DOT, R_N00, R_I00, R_M01, R_I10, R_K00);
      6'd17: i = mk(K_DOT, R_N00, R_I01, R_M01, R_I11, R_K01);
      6'd18: i = mk(K_DOT, R_N10, R_I00, R_N11, R_I10, R_K10);
      6'd19: i = mk(K_DOT, R_N10, R_I01, R_N11, R_I11, R_K11);
      6'd20: i = mk(K_SUB, C_ZA, R_XA, C_ZERO, C_ZERO, R_YA);
      6'd21: i = mk(K_SUB, C_ZR, R_EST1, C_ZERO, C_ZERO, R_YR);
      6'd22: i = mk(K_DOT, R_K00, R_YA, R_K01, R_YR, R_TMP);
      6'd23: i = mk(K_ADD, R_XA, R_TMP, C_ZERO, C_ZERO, R_EST0);
      6'd24: i = mk(K_DOT, R_K10, R_YA, R_K11, R_YR, R_TMP);
      6'd25: i = mk(K_ADD, R_EST1, R_TMP, C_ZERO, C_ZERO, R_EST1);
      6'd26: i = mk(K_SUB, C_ONE, R_K00, C_ZERO, C_ZERO, R_T00);
      6'd27: i = mk(K_SUB, C_ZERO, R_K01, C_ZERO, C_ZERO, R_T01);
      6'd28: i = mk(K_SUB, C_ZERO, R_K10, C_ZERO, C_ZERO, R_T10);
      6'd29: i = mk(K_SUB, C_ONE, R_K11, C_ZERO, C_ZERO, R_T11);
      6'd30: i = mk(K_DOT, R_T00, R_N00, R_T01, R_N10, R_P00);
      6'd31: i = mk(K_DOT, R_T00, R_M01, R_T01, R_N11, R_P01);
      6'd32: i = mk(K_DOT, R_T10, R_N00, R_T11, R_N10, R_P10);
      6'd33: i = mk(K_DOT, R_T10, R_M01, R_T11, R_N11, R_P11);
      6'd34: i = mk(K_ADD, C_ZA, C_ZERO, C_ZERO, C_ZERO, R_EST0);
      6'd35: i = mk(K_ADD, C_ZERO, C_ZERO, C_ZERO, C_ZERO, R_EST1);
      default: i = mk(K_ADD, C_ZERO, C_ZERO, C_ZERO, C_ZERO, R_TMP);
    endcase
    return i;
  endfunction

  // Saturate a wide signed value to DATA_W bits; the top bit of the result is
  // the saturation flag.
  function automatic logic [DATA_W:0] sat32(input logic signed [ACC_W-1:0] v);
    logic pos_ovf;
    logic neg_ovf;
    pos_ovf = !v[ACC_W-1] && (|v[ACC_W-2:DATA_W-1]);
    neg_ovf = v[ACC_W-1] && !(&v[ACC_W-2:DATA_W-1]);
    if (pos_ovf) begin
      return {1'b1, 1'b0, {(DATA_W-1){1'b1}}};
    end else if (neg_ovf) begin
      return {1'b1, 1'b1, {(DATA_W-1){1'b0}}};
    end
    return {1'b0, v[DATA_W-1:0]};
  endfunction

endpackage

`default_nettype wire

[rtl/tskf_in_if.sv]
// Input channel interface: valid/ready handshake with op and measurement payload.
// Depends on tskf_pkg.
`default_nettype none

interface tskf_in_if;
  import tskf_pkg::*;

  logic              valid;
  logic              ready;
  logic              op;
  logic [DATA_W-1:0] meas_angle;
  logic [DATA_W-1:0] meas_rate;

  modport source (output valid, output op, output meas_angle, output meas_rate,
                  input ready);
  modport sink (input valid, input op, input meas_angle, input meas_rate,
                output ready);
endinterface

`default_nettype wire

[rtl/tskf_out_if.sv]
// Output channel interface: valid/ready handshake with the estimate payload.
// Depends on tskf_pkg.
`default_nettype none

interface tskf_out_if;
  import tskf_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] est_angle;
  logic [DATA_W-1:0] est_rate;
  logic              saturated;

  modport source (output valid, output est_angle, output est_rate, output saturated,
                  input ready);
  modport sink (input valid, input est_angle, input est_rate, input saturated,
                output ready);
endinterface

`default_nettype wire

[rtl/tskf_ram.sv]
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
`default_nettype none

module tskf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]         rdata_a_o,
  output logic      [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

[rtl/tskf_div.sv]
// Signed fixed-point divider: (num << FRAC_BITS) / den, truncated toward zero and
// saturated, two quotient bits per cycle. Depends on tskf_pkg.
`default_nettype none

module tskf_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [tskf_pkg::DATA_W-1:0] num_i,
  input  wire logic [tskf_pkg::DATA_W-1:0] den_i,
  output logic                             done_o,
  output logic      [tskf_pkg::DATA_W-1:0] quo_o,
  output logic                             sat_o
);
  import tskf_pkg::*;

  logic [DATA_W-1:0]    rem_q, rem_d;
  logic [DIV_Q_W-1:0]   quo_q, quo_d;
  logic [DATA_W-1:0]    den_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q, done_q, neg_q, dz_q;
  logic [DATA_W-1:0]    num_mag, den_mag;
  logic [DATA_W:0]      trial;
  logic                 big, top, rest, pos_sat, neg_sat;

  assign num_mag = num_i[DATA_W-1] ? (~num_i + DATA_W'(1)) : num_i;
  assign den_mag = den_i[DATA_W-1] ? (~den_i + DATA_W'(1)) : den_i;

  // Two restoring steps per cycle.
  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    trial = '0;
    for (int s = 0; s < 2; s++) begin
      trial = {rem_d, quo_d[DIV_Q_W-1]};
      quo_d = {quo_d[DIV_Q_W-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        trial    = trial - {1'b0, den_q};
        quo_d[0] = 1'b1;
      end
      rem_d = trial[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(DIV_ITER);
      end else if (busy_q) begin
        cnt_q <= cnt_q - DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= DIV_Q_W'({num_mag, {FRAC_BITS{1'b0}}});
      den_q <= den_mag;
      neg_q <= num_i[DATA_W-1] ^ den_i[DATA_W-1];
      dz_q  <= (den_i == '0);
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign big     = |quo_q[DIV_Q_W-1:DATA_W];
  assign top     = quo_q[DATA_W-1];
  assign rest    = |quo_q[DATA_W-2:0];
  assign pos_sat = !neg_q && (big || top);
  assign neg_sat = neg_q && (big || (top && rest));

  always_comb begin
    if (dz_q) begin
      quo_o = '0;
    end else if (pos_sat) begin
      quo_o = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (neg_sat) begin
      quo_o = {1'b1, {(DATA_W-1){1'b0}}};
    end else if (neg_q) begin
      quo_o = ~quo_q[DATA_W-1:0] + DATA_W'(1);
    end else begin
      quo_o = quo_q[DATA_W-1:0];
    end
  end

  assign sat_o  = dz_q || pos_sat || neg_sat;
  assign done_o = done_q;

endmodule

`default_nettype wire

[rtl/tskf_datapath.sv]
// Datapath: scratch RAM, operand selection, one multiplier with accumulator,
// saturating adder, divider and output registers. Depends on tskf_pkg, tskf_ram
// and tskf_div.
`default_nettype none

module tskf_datapath (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire tskf_pkg::cmd_t              cmd_i,
  input  wire tskf_pkg::cfg_t              cfg_i,
  input  wire logic [tskf_pkg::DATA_W-1:0] meas_angle_i,
  input  wire logic [tskf_pkg::DATA_W-1:0] meas_rate_i,
  output logic                             div_done_o,
  output logic      [tskf_pkg::DATA_W-1:0] est_angle_o,
  output logic      [tskf_pkg::DATA_W-1:0] est_rate_o,
  output logic                             saturated_o
);
  import tskf_pkg::*;

  logic [DATA_W-1:0]        rdata_a, rdata_b, wdata, konst_a, konst_b;
  logic [SRC_W-1:0]         src_a_q, src_b_q;
  logic signed [DATA_W-1:0] op_a, op_b;
  logic signed [2*DATA_W-1:0] prod_q;
  logic signed [ACC_W-2:0]  acc_q;
  logic signed [ACC_W-1:0]  rsum, rnd, addsum;
  logic [DATA_W:0]          rnd_sat, add_sat;
  logic [DATA_W-1:0]        za_q, zr_q, est_a_q, est_r_q;
  logic [DATA_W-1:0]        out_a_q, out_r_q, div_quo;
  logic                     sat_q, out_sat_q, div_sat, we;

  tskf_ram #(.WIDTH(DATA_W), .DEPTH(RAM_DEPTH)) u_ram (
    .clk_i,
    .we_i      (we),
    .waddr_i   (cmd_i.dst),
    .wdata_i   (wdata),
    .raddr_a_i (cmd_i.src_a[ADDR_W-1:0]),
    .raddr_b_i (cmd_i.src_b[ADDR_W-1:0]),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  function automatic logic [DATA_W-1:0] konst(input logic [SRC_W-1:0] src,
                                              input cfg_t c,
                                              input logic [DATA_W-1:0] za,
                                              input logic [DATA_W-1:0] zr);
    case (src)
      C_ONE:   return ONE;
      C_DT:    return DATA_W'(c.step_time);
      C_QA:    return DATA_W'(c.process_noise_angle);
      C_QR:    return DATA_W'(c.process_noise_rate);
      C_RA:    return DATA_W'(c.meas_noise_angle);
      C_RR:    return DATA_W'(c.meas_noise_rate);
      C_ZA:    return za;
      C_ZR:    return zr;
      default: return '0;
    endcase
  endfunction

  assign konst_a = konst(src_a_q, cfg_i, za_q, zr_q);
  assign konst_b = konst(src_b_q, cfg_i, za_q, zr_q);
  assign op_a    = src_a_q[SRC_W-1] ? konst_a : rdata_a;
  assign op_b    = src_b_q[SRC_W-1] ? konst_b : rdata_b;

  // Round half up after dropping the fraction bits of the accumulated sum.
  assign rsum    = $signed({acc_q[ACC_W-2], acc_q}) + HALF;
  assign rnd     = rsum >>> FRAC_BITS;
  assign rnd_sat = sat32(rnd);

  assign addsum  = cmd_i.sub ? (ACC_W'(op_a) - ACC_W'(op_b)) : (ACC_W'(op_a) + ACC_W'(op_b));
  assign add_sat = sat32(addsum);

  tskf_div u_div (
    .clk_i,
    .rst_ni,
    .start_i (cmd_i.div_start),
    .num_i   (op_a),
    .den_i   (op_b),
    .done_o  (div_done_o),
    .quo_o   (div_quo),
    .sat_o   (div_sat)
  );

  assign we = cmd_i.clr_wr || cmd_i.round_wr || cmd_i.addsub_wr || cmd_i.div_wr;

  always_comb begin
    if (cmd_i.round_wr) begin
      wdata = rnd_sat[DATA_W-1:0];
    end else if (cmd_i.addsub_wr) begin
      wdata = add_sat[DATA_W-1:0];
    end else if (cmd_i.div_wr) begin
      wdata = div_quo;
    end else begin
      wdata = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      src_a_q <= cmd_i.src_a;
      src_b_q <= cmd_i.src_b;
    end
    if (cmd_i.mul_en) begin
      prod_q <= op_a * op_b;
    end
    if (cmd_i.acc_load) begin
      acc_q <= {prod_q[2*DATA_W-1], prod_q};
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_q + $signed({prod_q[2*DATA_W-1], prod_q});
    end else if (cmd_i.acc_sub) begin
      acc_q <= acc_q - $signed({prod_q[2*DATA_W-1], prod_q});
    end
    if (cmd_i.load_z) begin
      za_q <= meas_angle_i;
      zr_q <= meas_rate_i;
    end
    if (cmd_i.out_load) begin
      out_a_q   <= est_a_q;
      out_r_q   <= est_r_q;
      out_sat_q <= sat_q;
    end
  end

  // Copies of the estimate entries, so the result can be loaded without a read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      est_a_q <= '0;
      est_r_q <= '0;
      sat_q   <= 1'b0;
    end else begin
      if (we && (cmd_i.dst == R_EST0[ADDR_W-1:0])) begin
        est_a_q <= wdata;
      end
      if (we && (cmd_i.dst == R_EST1[ADDR_W-1:0])) begin
        est_r_q <= wdata;
      end
      if (cmd_i.clear_sat) begin
        sat_q <= 1'b0;
      end else if ((cmd_i.round_wr && rnd_sat[DATA_W]) ||
                   (cmd_i.addsub_wr && add_sat[DATA_W]) ||
                   (cmd_i.div_wr && div_sat)) begin
        sat_q <= 1'b1;
      end
    end
  end

  assign est_angle_o = out_a_q;
  assign est_rate_o  = out_r_q;
  assign saturated_o = out_sat_q;

endmodule

`default_nettype wire

[rtl/tskf_ctrl.sv]
// Controller: clearing pass, micro-program sequencer, and input and output handshakes.
// Drives the datapath through cmd_t. Depends on tskf_pkg.
`default_nettype none

module tskf_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire logic           in_op_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  input  wire logic           div_done_i,
  output tskf_pkg::cmd_t      cmd_o
);
  import tskf_pkg::*;

  localparam logic [1:0] ST_CLR  = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]      state_q, state_d;
  logic [PC_W-1:0] pc_q, pc_d, last_pc;
  logic [2:0]      phase_q, phase_d, clr_cnt_q, clr_cnt_d;
  logic            op_q, op_d, out_valid_q, out_valid_d, advance;
  instr_t          ins;
  cmd_t            cmd;

  assign ins     = prog(pc_q);
  assign last_pc = (op_q == OP_RELOAD) ? OP1_LAST : OP0_LAST;

  always_comb begin
    cmd       = '0;
    cmd.dst   = ins.dst;
    state_d   = state_q;
    pc_d      = pc_q;
    phase_d   = phase_q;
    clr_cnt_d = clr_cnt_q;
    op_d      = op_q;
    advance   = 1'b0;
    case (state_q)
      ST_CLR: begin
        cmd.clr_wr = 1'b1;
        cmd.dst    = ADDR_W'(clr_cnt_q);
        clr_cnt_d  = clr_cnt_q + 3'd1;
        if (clr_cnt_q == 3'(STATE_ENTRIES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd.load_z    = 1'b1;
          cmd.clear_sat = 1'b1;
          op_d          = in_op_i;
          pc_d          = (in_op_i == OP_RELOAD) ? OP1_FIRST : OP0_FIRST;
          phase_d       = 3'd0;
          state_d       = ST_RUN;
        end
      end
      ST_RUN: begin
        if (phase_q == 3'd0) begin
          cmd.rd    = 1'b1;
          cmd.src_a = ins.a;
          cmd.src_b = ins.b;
          phase_d   = 3'd1;
        end else begin
          case (ins.kind)
            K_ADD, K_SUB: begin
              cmd.addsub_wr = 1'b1;
              cmd.sub       = (ins.kind == K_SUB);
              advance       = 1'b1;
            end
            K_DOT, K_DET: begin
              case (phase_q)
                3'd1: begin
                  cmd.mul_en = 1'b1;
                  cmd.rd     = 1'b1;
                  cmd.src_a  = ins.c;
                  cmd.src_b  = ins.d;
                end
                3'd2: begin
                  cmd.acc_load = 1'b1;
                  cmd.mul_en   = 1'b1;
                end
                3'd3: begin
                  cmd.acc_add = (ins.kind == K_DOT);
                  cmd.acc_sub = (ins.kind == K_DET);
                end
                default: begin
                  cmd.round_wr = 1'b1;
                  advance      = 1'b1;
                end
              endcase
              phase_d = phase_q + 3'd1;
            end
            K_DIV: begin
              if (phase_q == 3'd1) begin
                cmd.div_start = 1'b1;
                phase_d       = 3'd2;
              end else if (div_done_i) begin
                cmd.div_wr = 1'b1;
                advance    = 1'b1;
              end
            end
            default: advance = 1'b1;
          endcase
          if (advance) begin
            phase_d = 3'd0;
            if (pc_q == last_pc) begin
              state_d = ST_FIN;
            end else begin
              pc_d = pc_q + PC_W'(1);
            end
          end
        end
      end
      default: begin
        if (!out_valid_q || out_ready_i) begin
          cmd.out_load = 1'b1;
          state_d      = ST_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      pc_q        <= '0;
      phase_q     <= '0;
      clr_cnt_q   <= '0;
      op_q        <= OP_STEP;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      phase_q     <= phase_d;
      clr_cnt_q   <= clr_cnt_d;
      op_q        <= op_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

`ifndef SYNTH
  a_pc_in_program: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (pc_q <= OP1_LAST))
    else $error("program counter left the program");

  a_accept_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_RUN))
    else $error("accepted beat did not start the sequencer");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |=> out_valid_q)
    else $error("result load did not raise output valid");

  a_clear_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLR && clr_cnt_q == 3'(STATE_ENTRIES - 1)) |=> (state_q == ST_IDLE))
    else $error("clearing pass did not end");
`endif

endmodule

`default_nettype wire

[rtl/two_state_kalman_filter.sv]
// Top level of the two-state Kalman filter: APB register file, controller and
// datapath. Depends on tskf_pkg, tskf_in_if, tskf_out_if, tskf_ctrl, tskf_datapath.
//
//   channel  direction  beat contents
//   in_if    sink       op, meas_angle, meas_rate
//   out_if   source     est_angle, est_rate, saturated
//   apb      slave      five registers at byte address 4*index
//
// A filter step runs 15 dot products and a determinant on the shared multiplier,
// 14 saturating adds, and 4 divisions in the radix-4 divider. A reload runs 2 adds.
// After reset a clearing pass zeroes the six state entries; no beat is taken then.
// The next beat is accepted while a result waits; that item stalls at its end.
`default_nettype none

module two_state_kalman_filter (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  tskf_in_if.sink                           in_if,
  tskf_out_if.source                        out_if,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [tskf_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                  pwdata,
  output logic      [31:0]                  prdata,
  output logic                              pready
);
  import tskf_pkg::*;

  cfg_t cfg_q;
  cmd_t cmd;
  logic div_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_time           <= STEP_TIME_RST;
      cfg_q.process_noise_angle <= PNOISE_ANG_RST;
      cfg_q.process_noise_rate  <= PNOISE_RAT_RST;
      cfg_q.meas_noise_angle    <= MNOISE_ANG_RST;
      cfg_q.meas_noise_rate     <= MNOISE_RAT_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        REG_STEP_TIME:  cfg_q.step_time           <= pwdata[DT_W-1:0];
        REG_PNOISE_ANG: cfg_q.process_noise_angle <= pwdata[NOISE_W-1:0];
        REG_PNOISE_RAT: cfg_q.process_noise_rate  <= pwdata[NOISE_W-1:0];
        REG_MNOISE_ANG: cfg_q.meas_noise_angle    <= pwdata[NOISE_W-1:0];
        REG_MNOISE_RAT: cfg_q.meas_noise_rate     <= pwdata[NOISE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_STEP_TIME:  prdata = 32'(cfg_q.step_time);
      REG_PNOISE_ANG: prdata = 32'(cfg_q.process_noise_angle);
      REG_PNOISE_RAT: prdata = 32'(cfg_q.process_noise_rate);
      REG_MNOISE_ANG: prdata = 32'(cfg_q.meas_noise_angle);
      REG_MNOISE_RAT: prdata = 32'(cfg_q.meas_noise_rate);
      default:        prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  tskf_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i  (in_if.valid),
    .in_op_i     (in_if.op),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .div_done_i  (div_done),
    .cmd_o       (cmd)
  );

  tskf_datapath u_datapath (
    .clk_i,
    .rst_ni,
    .cmd_i        (cmd),
    .cfg_i        (cfg_q),
    .meas_angle_i (in_if.meas_angle),
    .meas_rate_i  (in_if.meas_rate),
    .div_done_o   (div_done),
    .est_angle_o  (out_if.est_angle),
    .est_rate_o   (out_if.est_rate),
    .saturated_o  (out_if.saturated)
  );

endmodule

`default_nettype wire
